// ===== hdl/triangular_edge_weight_store_assert.svh =====
// assertion macros for the triangular edge weight store
// expects clk and rst in the scope of each use
`ifndef TRIANGULAR_EDGE_WEIGHT_STORE_ASSERT_SVH
`define TRIANGULAR_EDGE_WEIGHT_STORE_ASSERT_SVH

// same-cycle implication
`define TEWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tews assertion failed");

// next-cycle implication
`define TEWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tews assertion failed");

`endif

// ===== hdl/tews_pkg.sv =====
// shared types, codes and address helpers of the triangular edge weight store
// no dependencies
package tews_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 32;
  localparam int STORE_DEPTH  = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] MODE_GET    = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_MAX    = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NOEDGE  = 2'd2;

  typedef struct packed {
    logic [2:0]                    mode;
    logic [IDX_W-1:0]              index_a;
    logic [IDX_W-1:0]              index_b;
    logic signed [WEIGHT_BITS-1:0] weight_in;
  } tews_req_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_out;
    logic [IDX_W-1:0]              low_vertex;
    logic [IDX_W-1:0]              high_vertex;
    logic [1:0]                    status;
    logic [CNT_W-1:0]              live_count;
  } tews_rsp_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_DECODE,
    S_GET_RD,
    S_GET_WAIT,
    S_SET_WR,
    S_RM_RD,
    S_RM_WR,
    S_RM_ZR,
    S_MX,
    S_MX_END,
    S_CLR,
    S_DONE
  } tews_state_t;

  // flat position of edge (r, c), r > c
  function automatic logic [ADDR_W-1:0] flat_pos(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
    logic [2*CNT_W-1:0] prod;
    prod = r * (r - CNT_W'(1));
    return ADDR_W'(prod >> 1) + ADDR_W'(c);
  endfunction

endpackage

// ===== hdl/triangular_edge_weight_store.sv =====
// Symmetric edge weights of an undirected graph in a lower-triangular store
// (one single-port ram of 2016 Q16.16 words) plus a live vertex count. One
// request word gives one response word. Get and set each make one access
// to the ram. Remove reads and writes each edge moved, steps once per row
// walked and zeroes each word of the freed row; max-edge reads each live
// edge and clear writes every word; all are paced by the single ram port.
// After reset a zeroing pass over all 2016 words runs before the first request.
// depends on tews_pkg and tews_ctrl
module triangular_edge_weight_store import tews_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  tews_req_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output tews_rsp_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [CNT_W-1:0] initial_vertices;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_vertices <= CNT_W'(MAX_VERTICES);
    end else if (cfg_valid && cfg_ready) begin
      initial_vertices <= cfg_data;
    end
  end

  tews_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .initial_vertices (initial_vertices),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp)
  );

endmodule

// ===== hdl/tews_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module tews_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2016
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/tews_ctrl.sv =====
// sequencer for get, set, remove, max-edge and clear over the edge ram
// depends on tews_pkg, tews_ram and the assertion macro header
`include "triangular_edge_weight_store_assert.svh"
module tews_ctrl import tews_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] initial_vertices,
  input  logic             req_valid,
  output logic             req_stall,
  input  tews_req_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output tews_rsp_t        rsp
);

  tews_state_t state, state_next;
  tews_req_t   cmd;
  logic [CNT_W-1:0] cnt, n, i, j, sj;
  logic [CNT_W-1:0] a, r, c;
  logic [ADDR_W-1:0] addr, rbase, dp, p;
  logic [CNT_W-1:0] clr_cnt;
  logic first, pv, issuing;
  logic [IDX_W-1:0] pi, pj, bi, bj;
  logic signed [WEIGHT_BITS-1:0] best, res_w;
  logic [1:0] res_st;
  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
  logic rsp_load;

  tews_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign a       = CNT_W'(cmd.index_a);
  assign r       = (cmd.index_a > cmd.index_b) ? CNT_W'(cmd.index_a) : CNT_W'(cmd.index_b);
  assign c       = (cmd.index_a > cmd.index_b) ? CNT_W'(cmd.index_b) : CNT_W'(cmd.index_a);
  assign n       = cnt - CNT_W'(1);
  assign sj      = (j < a) ? j : j + CNT_W'(1);
  assign issuing = i < cnt;
  assign clr_cnt = (initial_vertices > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : initial_vertices;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT_CLR: if (p == ADDR_W'(STORE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:     if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (cmd.mode)
          MODE_GET:    state_next = ((r == c) || (r >= cnt)) ? S_DONE : S_GET_RD;
          MODE_SET:    state_next = ((r == c) || (r >= cnt)) ? S_DONE : S_SET_WR;
          MODE_REMOVE: state_next = (a >= cnt) ? S_DONE : S_RM_RD;
          MODE_MAX:    state_next = (cnt < CNT_W'(2)) ? S_DONE : S_MX;
          MODE_CLEAR:  state_next = S_CLR;
          default:     state_next = S_DONE;
        endcase
      end
      S_GET_RD:   state_next = S_GET_WAIT;
      S_GET_WAIT: state_next = S_DONE;
      S_SET_WR:   state_next = S_DONE;
      S_RM_RD: begin
        if (i == n) begin
          state_next = S_RM_ZR;
        end else if (j != i) begin
          state_next = S_RM_WR;
        end
      end
      S_RM_WR:    state_next = S_RM_RD;
      S_RM_ZR:    if (j == n) state_next = S_DONE;
      S_MX:       if (!issuing && !pv) state_next = S_MX_END;
      S_MX_END:   state_next = S_DONE;
      S_CLR:      if (p == ADDR_W'(STORE_DEPTH - 1)) state_next = S_DONE;
      S_DONE:     if (rsp_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs to ram and request side
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr;
    ram_wdata = '0;
    req_stall = (state != S_IDLE);
    case (state)
      S_INIT_CLR, S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = p;
      end
      S_GET_RD: ram_addr = addr;
      S_SET_WR: begin
        ram_we    = 1'b1;
        ram_addr  = addr;
        ram_wdata = cmd.weight_in;
      end
      S_RM_RD: ram_addr = rbase + ADDR_W'(sj);
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_addr  = dp;
        ram_wdata = ram_rdata;
      end
      S_RM_ZR: begin
        ram_we   = (j != n);
        ram_addr = dp;
      end
      S_MX:    ram_addr = p;
      default: ram_addr = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_CLR;
      cnt       <= CNT_W'(MAX_VERTICES);
      p         <= '0;
      pv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT_CLR: p <= p + ADDR_W'(1);
        S_IDLE:     if (req_valid) cmd <= req;
        S_DECODE: begin
          addr  <= flat_pos(r, c);
          rbase <= flat_pos(a + CNT_W'(1), '0);
          dp    <= flat_pos(a, '0);
          i     <= (cmd.mode == MODE_MAX) ? CNT_W'(1) : a;
          j     <= '0;
          p     <= '0;
          pv    <= 1'b0;
          first <= 1'b1;
          bi    <= '0;
          bj    <= '0;
          best  <= '0;
          res_w <= '0;
          case (cmd.mode)
            MODE_GET, MODE_SET: res_st <= ((r == c) || (r >= cnt)) ? ST_IGNORED : ST_OK;
            MODE_REMOVE:        res_st <= (a >= cnt) ? ST_IGNORED : ST_OK;
            MODE_MAX:           res_st <= (cnt < CNT_W'(2)) ? ST_NOEDGE : ST_OK;
            MODE_CLEAR:         res_st <= ST_OK;
            default:            res_st <= ST_IGNORED;
          endcase
        end
        S_GET_WAIT: res_w <= ram_rdata;
        S_RM_RD: begin
          if ((i != n) && (j == i)) begin
            rbase <= rbase + ADDR_W'(i) + ADDR_W'(1);
            i     <= i + CNT_W'(1);
            j     <= '0;
          end else if (i == n) begin
            j <= '0;
          end
        end
        S_RM_WR: begin
          dp <= dp + ADDR_W'(1);
          j  <= j + CNT_W'(1);
        end
        S_RM_ZR: begin
          if (j == n) begin
            cnt <= n;
          end else begin
            dp <= dp + ADDR_W'(1);
            j  <= j + CNT_W'(1);
          end
        end
        S_MX: begin
          pv <= issuing;
          if (issuing) begin
            pi <= IDX_W'(i);
            pj <= IDX_W'(j);
            p  <= p + ADDR_W'(1);
            if (j + CNT_W'(1) == i) begin
              i <= i + CNT_W'(1);
              j <= '0;
            end else begin
              j <= j + CNT_W'(1);
            end
          end
          if (pv && (first || ($signed(ram_rdata) > best))) begin
            first <= 1'b0;
            best  <= ram_rdata;
            bi    <= pi;
            bj    <= pj;
          end
        end
        S_MX_END: res_w <= best;
        S_CLR: begin
          p <= p + ADDR_W'(1);
          if (p == ADDR_W'(STORE_DEPTH - 1)) cnt <= clr_cnt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.weight_out  <= res_w;
      rsp.low_vertex  <= bj;
      rsp.high_vertex <= bi;
      rsp.status      <= res_st;
      rsp.live_count  <= cnt;
    end
  end

  `TEWS_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CNT_W'(MAX_VERTICES))
  `TEWS_ASSERT_NOW(a_rm_wr_after_rd, state == S_RM_WR, $past(state) == S_RM_RD)
  `TEWS_ASSERT_NOW(a_mx_lower, pv && state == S_MX, pi > pj)
  `TEWS_ASSERT_NEXT(a_rsp_after_load, rsp_load, rsp_valid)

endmodule

// ===== sim/testbench.sv =====
// testbench of the triangular edge weight store: directed and random request words
// checked against an in-bench graph model, under several idle and stall patterns
// depends on tews_pkg and triangular_edge_weight_store
module testbench;
  import tews_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 4200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  tews_req_t req;
  logic rsp_valid;
  logic rsp_stall;
  tews_rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  // graph model state
  logic signed [WEIGHT_BITS-1:0] edge_wt [0:STORE_DEPTH-1];
  int live_vertices;
  int clear_vertices;

  tews_rsp_t expected_rsp [$];
  int errors;
  int words_checked;
  int words_sent;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  triangular_edge_weight_store u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int edge_pos(int r, int c);
    return r * (r - 1) / 2 + c;
  endfunction

  function automatic tews_rsp_t model_edge_op(tews_req_t r);
    tews_rsp_t res;
    int hi, lo, n, si, sj, bi, bj;
    logic signed [WEIGHT_BITS-1:0] best;
    res = '0;
    case (r.mode)
      MODE_GET, MODE_SET: begin
        hi = (r.index_a > r.index_b) ? r.index_a : r.index_b;
        lo = (r.index_a > r.index_b) ? r.index_b : r.index_a;
        if (hi == lo || hi >= live_vertices) res.status = ST_IGNORED;
        else if (r.mode == MODE_GET) res.weight_out = edge_wt[edge_pos(hi, lo)];
        else edge_wt[edge_pos(hi, lo)] = r.weight_in;
      end
      MODE_REMOVE: begin
        if (r.index_a >= live_vertices) begin
          res.status = ST_IGNORED;
        end else begin
          n = live_vertices - 1;
          for (int i = r.index_a; i < n; i++) begin
            for (int j = 0; j < i; j++) begin
              si = i + 1;
              sj = (j >= r.index_a) ? j + 1 : j;
              edge_wt[edge_pos(i, j)] = edge_wt[edge_pos(si, sj)];
            end
          end
          for (int j = 0; j < n; j++) edge_wt[edge_pos(n, j)] = '0;
          live_vertices = n;
        end
      end
      MODE_MAX: begin
        if (live_vertices < 2) begin
          res.status = ST_NOEDGE;
        end else begin
          bi = 1;
          bj = 0;
          best = edge_wt[0];
          for (int i = 1; i < live_vertices; i++) begin
            for (int j = 0; j < i; j++) begin
              if (edge_wt[edge_pos(i, j)] > best) begin
                best = edge_wt[edge_pos(i, j)];
                bi = i;
                bj = j;
              end
            end
          end
          res.weight_out = best;
          res.low_vertex = IDX_W'(bj);
          res.high_vertex = IDX_W'(bi);
        end
      end
      MODE_CLEAR: begin
        for (int k = 0; k < STORE_DEPTH; k++) edge_wt[k] = '0;
        live_vertices = (clear_vertices > MAX_VERTICES) ? MAX_VERTICES : clear_vertices;
      end
      default: res.status = ST_IGNORED;
    endcase
    res.live_count = CNT_W'(live_vertices);
    return res;
  endfunction

  always @(negedge clk) begin
    if (!rst) rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    tews_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("response word with none expected");
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        words_checked++;
        if (rsp.weight_out !== want.weight_out) begin
          $error("weight_out expected %0d actual %0d", want.weight_out, rsp.weight_out);
          errors++;
        end
        if (rsp.low_vertex !== want.low_vertex) begin
          $error("low_vertex expected %0d actual %0d", want.low_vertex, rsp.low_vertex);
          errors++;
        end
        if (rsp.high_vertex !== want.high_vertex) begin
          $error("high_vertex expected %0d actual %0d", want.high_vertex, rsp.high_vertex);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.live_count !== want.live_count) begin
          $error("live_count expected %0d actual %0d", want.live_count, rsp.live_count);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic [2:0] mode, int a, int b, logic [31:0] w);
    tews_req_t r;
    int gap;
    r.mode = mode;
    r.index_a = IDX_W'(a);
    r.index_b = IDX_W'(b);
    r.weight_in = w;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    expected_rsp.push_back(model_edge_op(r));
    words_sent++;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_clear_count(int v);
    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 7'(v);
    do @(posedge clk); while (!cfg_ready);
    clear_vertices = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(2) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index();
    if (live_vertices > 0 && $urandom_range(9) != 0) return $urandom_range(live_vertices - 1);
    return $urandom_range(63);
  endfunction

  task automatic test_directed();
    send_word(MODE_GET, 1, 0, 0);
    send_word(MODE_SET, 63, 0, 32'h7fffffff);
    send_word(MODE_SET, 0, 62, 32'h80000000);
    send_word(MODE_SET, 5, 9, 32'hffffffff);
    send_word(MODE_GET, 0, 63, 0);
    send_word(MODE_GET, 62, 0, 0);
    send_word(MODE_GET, 5, 5, 0);
    send_word(MODE_SET, 7, 7, 32'h12345678);
    send_word(MODE_MAX, 0, 0, 0);
    send_word(MODE_REMOVE, 63, 0, 0);
    send_word(MODE_MAX, 0, 0, 0);
    send_word(MODE_REMOVE, 0, 0, 0);
    send_word(MODE_GET, 61, 4, 0);
    send_word(MODE_GET, 63, 1, 0);
    send_word(MODE_REMOVE, 63, 0, 0);
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) send_word(3'(m), 1, 0, 32'h1);
    write_clear_count(1);
    send_word(MODE_CLEAR, 0, 0, 0);
    send_word(MODE_MAX, 0, 0, 0);
    write_clear_count(0);
    send_word(MODE_CLEAR, 0, 0, 0);
    send_word(MODE_REMOVE, 0, 0, 0);
    write_clear_count(2);
    send_word(MODE_CLEAR, 0, 0, 0);
    send_word(MODE_SET, 1, 0, 32'hffffffff);
    send_word(MODE_MAX, 0, 0, 0);
    write_clear_count(127);
    send_word(MODE_CLEAR, 0, 0, 0);
    send_word(MODE_GET, 63, 62, 0);
  endtask

  task automatic test_random(int n, int vertices, int idle_pct, int stall_pct);
    int roll;
    write_clear_count(vertices);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_word(MODE_CLEAR, 0, 0, 0);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (k == n / 2) wait_drained();
      if (roll < 38) send_word(MODE_GET, pick_index(), pick_index(), $urandom);
      else if (roll < 80) send_word(MODE_SET, pick_index(), pick_index(), pick_weight());
      else if (roll < 87) send_word(MODE_REMOVE, pick_index(), $urandom_range(63), $urandom);
      else if (roll < 95) send_word(MODE_MAX, $urandom_range(63), $urandom_range(63), $urandom);
      else if (roll < 97) send_word(MODE_CLEAR, $urandom_range(63), $urandom_range(63), $urandom);
      else send_word(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), $urandom_range(63),
                     $urandom_range(63), $urandom);
    end
  endtask

  initial begin
    errors = 0;
    words_checked = 0;
    words_sent = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int k = 0; k < STORE_DEPTH; k++) edge_wt[k] = '0;
    clear_vertices = 64;
    live_vertices = 64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(230, 64, 0, 0);
    test_random(230, 8, 68, 0);
    test_random(230, 3, 0, 68);
    test_random(230, 20, 24, 24);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered get, set, remove, max-edge, clear and unused modes over clear counts");
    $display("0 to 127; %0d request words sent, %0d response words checked", words_sent,
             words_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tews_pkg.sv
hdl/tews_ram.sv
hdl/tews_ctrl.sv
hdl/triangular_edge_weight_store.sv
sim/testbench.sv
